### src/lbg_pkg.sv
// Shared types, register codes and constants for the LED bar graph pattern generator.
`default_nettype none

package lbg_pkg;

    // Field widths of the request and result items.
    localparam int LBG_VALUE_W    = 7;
    localparam int LBG_TIME_W     = 32;
    localparam int LBG_MASK_W     = 16;
    localparam int LBG_HIGH_W     = 7;
    localparam int LBG_INTERVAL_W = 16;

    // Configuration port shape: four registers, data as wide as the widest one.
    localparam int LBG_CFG_IDX_W  = 2;
    localparam int LBG_CFG_DATA_W = 16;

    localparam int LBG_NUM_LEDS_DEFAULT = 16;

    // Register indexes on the configuration port.
    localparam logic [LBG_CFG_IDX_W-1:0] LBG_REG_FILL_PATTERN = 2'd0;
    localparam logic [LBG_CFG_IDX_W-1:0] LBG_REG_HIGH_PERCENT = 2'd1;
    localparam logic [LBG_CFG_IDX_W-1:0] LBG_REG_FLASH_ENABLE = 2'd2;
    localparam logic [LBG_CFG_IDX_W-1:0] LBG_REG_FLASH_INTERVAL = 2'd3;

    // Full scale of a reading; a reading plus the band width at or above this is in the band.
    localparam logic [LBG_VALUE_W:0] LBG_FULL_SCALE = 8'd100;

    // Division by 100 as a multiply by a scaled reciprocal, exact for products below 2^15.
    localparam int LBG_DIV100_SHIFT = 20;
    localparam int LBG_DIV100_MUL   = (1 << LBG_DIV100_SHIFT) / 100 + 1;

    // Division by 10 of a seven bit reading, exact over the whole range.
    localparam int LBG_DIV10_SHIFT = 11;
    localparam logic [7:0] LBG_DIV10_MUL = 8'd205;
    localparam logic [3:0] LBG_TEN       = 4'd10;
    localparam logic [LBG_VALUE_W-1:0] LBG_ROUND_LIMIT = 7'd5;

    localparam logic [LBG_INTERVAL_W-1:0] LBG_INTERVAL_RESET = 16'd100;

    typedef enum logic [1:0] {
        PAT_LEFT   = 2'd0,
        PAT_RIGHT  = 2'd1,
        PAT_CENTER = 2'd2,
        PAT_EDGES  = 2'd3
    } lbg_pattern_t;

    typedef struct packed {
        logic [LBG_VALUE_W-1:0] value_percent;
        logic [LBG_TIME_W-1:0]  now_ms;
    } lbg_in_t;

    typedef struct packed {
        logic [LBG_MASK_W-1:0] led_mask;
        logic                  blink_phase;
    } lbg_out_t;

    typedef struct packed {
        lbg_pattern_t              fill_pattern;
        logic [LBG_HIGH_W-1:0]     high_percent;
        logic                      flash_enable;
        logic [LBG_INTERVAL_W-1:0] flash_interval_ms;
    } lbg_cfg_t;

endpackage

`default_nettype wire

### src/lbg_count.sv
// Lit LED count from a percentage reading, with rounding and saturation.
`default_nettype none

module lbg_count #(
    parameter int NUM_LEDS = lbg_pkg::LBG_NUM_LEDS_DEFAULT
) (
    input  wire logic [lbg_pkg::LBG_VALUE_W-1:0] value_percent,
    output logic [$clog2(NUM_LEDS+1)-1:0]        count
);
    import lbg_pkg::*;

    localparam int CNT_W  = $clog2(NUM_LEDS + 1);
    localparam int MULT   = NUM_LEDS * LBG_DIV100_MUL;
    localparam int PROD_W = LBG_VALUE_W + $clog2(MULT + 1);
    localparam int Q_W    = PROD_W - LBG_DIV100_SHIFT;
    localparam int D10_W  = LBG_VALUE_W + 8;

    logic [PROD_W-1:0]      prod;
    logic [Q_W-1:0]         quot;
    logic [CNT_W-1:0]       base;
    logic [D10_W-1:0]       prod10;
    logic [3:0]             tens;
    logic [LBG_VALUE_W-1:0] rem;
    logic                   round_up;

    // value * NUM_LEDS / 100 folded into one constant multiply.
    assign prod = PROD_W'(value_percent) * PROD_W'(MULT);
    assign quot = prod[PROD_W-1:LBG_DIV100_SHIFT];

    always_comb
    begin
        if (quot > Q_W'(NUM_LEDS))
        begin
            base = CNT_W'(NUM_LEDS);
        end
        else
        begin
            base = CNT_W'(quot);
        end
    end

    assign prod10   = D10_W'(value_percent) * D10_W'(LBG_DIV10_MUL);
    assign tens     = prod10[LBG_DIV10_SHIFT+3:LBG_DIV10_SHIFT];
    assign rem      = value_percent - LBG_VALUE_W'(tens) * LBG_VALUE_W'(LBG_TEN);
    assign round_up = (rem >= LBG_ROUND_LIMIT) && (base < CNT_W'(NUM_LEDS));
    assign count    = round_up ? base + CNT_W'(1) : base;

endmodule

`default_nettype wire

### src/lbg_mask.sv
// Places the lit LEDs according to the selected fill pattern.
`default_nettype none

module lbg_mask #(
    parameter int NUM_LEDS = lbg_pkg::LBG_NUM_LEDS_DEFAULT
) (
    input  wire lbg_pkg::lbg_pattern_t          fill_pattern,
    input  wire logic [$clog2(NUM_LEDS+1)-1:0]  count,
    output logic [NUM_LEDS-1:0]                 mask
);
    import lbg_pkg::*;

    localparam int CNT_W = $clog2(NUM_LEDS + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam int MID   = NUM_LEDS / 2;

    logic [SUM_W-1:0] cnt_x;
    logic [SUM_W-1:0] half;

    assign cnt_x = SUM_W'(count);
    assign half  = SUM_W'(count >> 1);

    // Each LED is decided on its own; the middle LED of the centre pattern lights at zero.
    always_comb
    begin
        for (int i = 0; i < NUM_LEDS; i++)
        begin
            unique case (fill_pattern)
                PAT_LEFT:   mask[i] = SUM_W'(i) < cnt_x;
                PAT_RIGHT:  mask[i] = (SUM_W'(i) + cnt_x) >= SUM_W'(NUM_LEDS);
                PAT_CENTER: mask[i] = ((SUM_W'(i) + half) >= SUM_W'(MID))
                                      && (SUM_W'(i) <= (SUM_W'(MID) + half));
                PAT_EDGES:  mask[i] = (SUM_W'(i) < half)
                                      || ((SUM_W'(i) + half) >= SUM_W'(NUM_LEDS));
            endcase
        end
    end

endmodule

`default_nettype wire

### src/lbg_blink.sv
// Blink phase state and the interval timer on the request timestamps.
`default_nettype none

module lbg_blink (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire lbg_pkg::lbg_cfg_t              cfg,
    input  wire logic                           step,
    input  wire logic                           in_band,
    input  wire logic [lbg_pkg::LBG_TIME_W-1:0] now_ms,
    output logic                                blink_on
);
    import lbg_pkg::*;

    logic                  blink_on_reg;
    logic                  blink_on_next;
    logic [LBG_TIME_W-1:0] last_toggle_reg;
    logic [LBG_TIME_W-1:0] last_toggle_next;
    logic [LBG_TIME_W-1:0] elapsed;
    logic                  flashing;

    assign flashing = cfg.flash_enable && in_band;
    // Wraps modulo 2^32 with the free-running timestamp.
    assign elapsed  = now_ms - last_toggle_reg;

    always_comb
    begin
        blink_on_next    = blink_on_reg;
        last_toggle_next = last_toggle_reg;
        if (flashing)
        begin
            if (elapsed >= LBG_TIME_W'(cfg.flash_interval_ms))
            begin
                blink_on_next    = !blink_on_reg;
                last_toggle_next = now_ms;
            end
        end
        else
        begin
            blink_on_next = 1'b1;
        end
    end

    assign blink_on = blink_on_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blink_on_reg    <= 1'b1;
            last_toggle_reg <= '0;
        end
        else if (step)
        begin
            blink_on_reg    <= blink_on_next;
            last_toggle_reg <= last_toggle_next;
        end
    end

    a_forced_lit: assert property (@(posedge clk) disable iff (!rst_n)
        step && !flashing |=> blink_on_reg)
        else $error("blink phase not forced to lit outside the flashing band");

    a_toggle_time_held: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> $stable(last_toggle_reg) && $stable(blink_on_reg))
        else $error("blink state changed without a request being processed");

endmodule

`default_nettype wire

### src/led_bar_graph_pattern.sv
// Top level of the LED bar graph pattern generator: handshake stages, configuration and result.
`default_nettype none

// Each request carries a reading in percent and a millisecond timestamp and yields one LED mask.
// The block takes one request per clock cycle while the output is not stalled; each request
// waits in the input register and then passes the count, pattern and blink logic on its way to
// the result register. A result waiting on a stalled output does not stop the input register
// from taking a new request while it is empty. The lit count is value * NUM_LEDS / 100, raised by
// one when the reading ends in 5 to 9 and the bar is not yet full; readings above 100 saturate.
// With flashing enabled and the reading in the top band, the blink phase toggles whenever the
// time since the last toggle reaches the interval, and the mask is dark in the unlit phase.
// Configuration is written through a plain write port and should only change while idle.
module led_bar_graph_pattern #(
    parameter int NUM_LEDS = lbg_pkg::LBG_NUM_LEDS_DEFAULT
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire lbg_pkg::lbg_in_t                   in_data,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output lbg_pkg::lbg_out_t                       out_data,
    input  wire logic                               cfg_write_en,
    input  wire logic [lbg_pkg::LBG_CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [lbg_pkg::LBG_CFG_DATA_W-1:0] cfg_data
);
    import lbg_pkg::*;

    localparam int CNT_W    = $clog2(NUM_LEDS + 1);
    localparam int OUT_LEDS = (NUM_LEDS < LBG_MASK_W) ? NUM_LEDS : LBG_MASK_W;

    lbg_cfg_t               cfg_reg;
    logic                   s1_valid_reg;
    lbg_in_t                s1_data_reg;
    logic                   out_valid_reg;
    lbg_out_t               out_data_reg;
    lbg_out_t               out_data_next;
    logic                   s1_adv;
    logic [CNT_W-1:0]       count;
    logic [NUM_LEDS-1:0]    mask;
    logic                   in_band;
    logic                   blink_on;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fill_pattern      <= PAT_LEFT;
            cfg_reg.high_percent      <= '0;
            cfg_reg.flash_enable      <= 1'b0;
            cfg_reg.flash_interval_ms <= LBG_INTERVAL_RESET;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                LBG_REG_FILL_PATTERN:   cfg_reg.fill_pattern <= lbg_pattern_t'(cfg_data[1:0]);
                LBG_REG_HIGH_PERCENT:   cfg_reg.high_percent <= cfg_data[LBG_HIGH_W-1:0];
                LBG_REG_FLASH_ENABLE:   cfg_reg.flash_enable <= cfg_data[0];
                LBG_REG_FLASH_INTERVAL: cfg_reg.flash_interval_ms <= cfg_data;
            endcase
        end
    end

    // The input register moves on whenever the result register is empty or being emptied,
    // so a new request may enter in the same cycle as the previous one moves forward.
    assign s1_adv   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_data_reg <= in_data;
        end
    end

    // The band test compares the reading against the top band, widened to avoid overflow.
    assign in_band = ((LBG_VALUE_W + 1)'(s1_data_reg.value_percent)
                      + (LBG_VALUE_W + 1)'(cfg_reg.high_percent)) >= LBG_FULL_SCALE;

    lbg_count #(
        .NUM_LEDS (NUM_LEDS)
    ) u_count (
        .value_percent (s1_data_reg.value_percent),
        .count         (count)
    );

    lbg_mask #(
        .NUM_LEDS (NUM_LEDS)
    ) u_mask (
        .fill_pattern (cfg_reg.fill_pattern),
        .count        (count),
        .mask         (mask)
    );

    // The blink state advances only when the request leaves the input register.
    lbg_blink u_blink (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .step     (s1_adv),
        .in_band  (in_band),
        .now_ms   (s1_data_reg.now_ms),
        .blink_on (blink_on)
    );

    // LEDs beyond the sixteen output bits are dropped; a shorter bar is zero padded.
    always_comb
    begin
        out_data_next.blink_phase = blink_on;
        if (!blink_on && in_band)
        begin
            out_data_next.led_mask = '0;
        end
        else
        begin
            out_data_next.led_mask = LBG_MASK_W'(mask[OUT_LEDS-1:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_dark_phase: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_data_reg.blink_phase |-> out_data_reg.led_mask == '0)
        else $error("unlit blink phase delivered with LEDs lit");

    a_request_kept: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_adv |=> s1_valid_reg)
        else $error("request dropped from the input register while stalled");

endmodule

`default_nettype wire
